// ===== hw/rtl/rtlpm_pkg.sv =====
// Shared types and constants for the routing table LPM engine.
// Route entry layout, request codes and controller states.
// No dependencies.
package rtlpm_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int IP_W            = 32;
	localparam int LEN_W           = 6;
	localparam int IF_W            = 4;
	localparam int MET_W           = 5;
	localparam int REQ_W           = 2;
	localparam int CNT_OUT_W       = 9;
	localparam int FULL_LEN        = 32;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_QUERY  = 2'd2,
		REQ_MERGE  = 2'd3
	} req_t;

	typedef struct packed {
		logic [IP_W-1:0]  pfx;
		logic [LEN_W-1:0] len;
		logic [IP_W-1:0]  nh;
		logic [IF_W-1:0]  ifc;
		logic [MET_W-1:0] met;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_MOVE,
		ST_APPEND,
		ST_DONE
	} state_t;

	// Low-order mask of a prefix length; lengths of 32 and above compare all bits.
	function automatic logic [IP_W-1:0] low_mask(input logic [LEN_W-1:0] len);
		logic [IP_W-1:0] m;
		if (len >= LEN_W'(FULL_LEN))
			m = '1;
		else
			m = ~({IP_W{1'b1}} << len[4:0]);
		return m;
	endfunction

endpackage

// ===== hw/rtl/rtlpm_mem.sv =====
// Route table storage: one write port, one read port, registered read data.
// Depends on rtlpm_pkg for the entry layout.
module rtlpm_mem
	import rtlpm_pkg::*;
#(
	parameter int DEPTH = TABLE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/rtlpm_ctrl.sv =====
// Request sequencer: scans the table, compacts after a removal, appends,
// and tracks the longest-prefix match. Depends on rtlpm_pkg.
module rtlpm_ctrl
	import rtlpm_pkg::*;
#(
	parameter int DEPTH = TABLE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [REQ_W-1:0]     req_type,
	input  logic [IP_W-1:0]      prefix_addr,
	input  logic [LEN_W-1:0]     prefix_len,
	input  logic [IP_W-1:0]      route_next_hop,
	input  logic [IF_W-1:0]      route_iface,
	input  logic [MET_W-1:0]     route_metric,
	input  logic [IP_W-1:0]      lookup_addr,
	output logic                 done,
	output logic                 found,
	output logic [IP_W-1:0]      out_next_hop,
	output logic [IF_W-1:0]      out_iface,
	output logic                 status,
	output logic [CNT_OUT_W-1:0] entry_count,
	output logic                 wr_en,
	output logic [AW-1:0]        wr_addr,
	output entry_t               wr_data,
	output logic                 rd_en,
	output logic [AW-1:0]        rd_addr,
	input  entry_t               rd_data
);

	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	state_t state_q, state_d;

	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    idx_q;
	logic             vld_s1;
	logic [CW-1:0]    idx_s1;
	logic             hit_q;
	logic [CW-1:0]    pos_q;
	logic             app_q;
	logic             status_q;
	logic [LEN_W-1:0] best_len_q;
	logic [IP_W-1:0]  best_nh_q;
	logic [IF_W-1:0]  best_if_q;
	logic [IP_W-1:0]  old_nh_q;
	logic [IF_W-1:0]  old_if_q;
	logic [MET_W-1:0] old_met_q;

	req_t             req_q;
	logic [IP_W-1:0]  pfx_q;
	logic [LEN_W-1:0] len_q;
	logic [IP_W-1:0]  nh_q;
	logic [IF_W-1:0]  ifc_q;
	logic [MET_W-1:0] met_q;
	logic [IP_W-1:0]  addr_q;

	logic             accept;
	logic             key_hit;
	logic             lpm_hit;
	logic             scan_end;
	logic             move_end;
	logic             merge_ok;
	logic             do_move;
	logic             do_append;
	logic [CW+CNT_OUT_W-1:0] cnt_ext;

	assign accept = start && (state_q == ST_IDLE);

	assign key_hit = (state_q == ST_SCAN) && vld_s1 && (req_q != REQ_QUERY)
		&& (rd_data.pfx == pfx_q) && (rd_data.len == len_q);
	assign lpm_hit = (state_q == ST_SCAN) && vld_s1 && (req_q == REQ_QUERY)
		&& (((rd_data.pfx ^ addr_q) & low_mask(rd_data.len)) == '0)
		&& (rd_data.len > best_len_q);

	// A scan ends on the first key hit, or once every read has come back.
	assign scan_end = (state_q == ST_SCAN) && (key_hit || (!vld_s1 && idx_q >= cnt_q));
	assign move_end = (state_q == ST_MOVE) && !vld_s1 && (idx_q >= cnt_q);

	assign merge_ok = ((ifc_q == old_if_q) || (met_q <= old_met_q)) && (old_nh_q != '0);

	always_comb begin
		unique case (req_q)
			REQ_INSERT: begin
				do_move   = hit_q;
				do_append = 1'b1;
			end
			REQ_DELETE: begin
				do_move   = hit_q;
				do_append = 1'b0;
			end
			REQ_QUERY: begin
				do_move   = 1'b0;
				do_append = 1'b0;
			end
			REQ_MERGE: begin
				do_move   = hit_q && merge_ok;
				do_append = !hit_q || merge_ok;
			end
			default: begin
				do_move   = 1'b0;
				do_append = 1'b0;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_end) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (do_move)        state_d = ST_MOVE;
				else if (do_append) state_d = ST_APPEND;
				else                state_d = ST_DONE;
			end
			ST_MOVE: begin
				if (move_end) state_d = app_q ? ST_APPEND : ST_DONE;
			end
			ST_APPEND: state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Memory port and handshake outputs
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = cnt_q[AW-1:0];
		wr_data = '{pfx: pfx_q, len: len_q, nh: nh_q, ifc: ifc_q, met: met_q};
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			ST_IDLE: busy = 1'b0;
			ST_SCAN: rd_en = (idx_q < cnt_q) && !key_hit;
			ST_DECIDE: ;
			ST_MOVE: begin
				// Read entry i+1 while writing the one fetched last cycle down by one.
				rd_en   = idx_q < cnt_q;
				wr_en   = vld_s1;
				wr_addr = AW'(idx_s1 - ONE_C);
				wr_data = rd_data;
			end
			ST_APPEND: wr_en = cnt_q < DEPTH_C;
			ST_DONE:   done = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			idx_q      <= '0;
			vld_s1     <= 1'b0;
			hit_q      <= 1'b0;
			app_q      <= 1'b0;
			status_q   <= 1'b0;
			best_len_q <= '0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_en;
			if (accept) begin
				idx_q      <= '0;
				hit_q      <= 1'b0;
				status_q   <= 1'b0;
				best_len_q <= '0;
			end
			if (rd_en) begin
				idx_q <= idx_q + ONE_C;
			end
			if (key_hit) begin
				hit_q <= 1'b1;
			end
			if (lpm_hit) begin
				best_len_q <= rd_data.len;
			end
			if (state_q == ST_DECIDE) begin
				idx_q <= pos_q + ONE_C;
				app_q <= do_append;
			end
			if (move_end) begin
				cnt_q <= cnt_q - ONE_C;
			end
			if (state_q == ST_APPEND) begin
				if (cnt_q < DEPTH_C) cnt_q <= cnt_q + ONE_C;
				else                 status_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (accept) begin
			req_q  <= req_t'(req_type);
			pfx_q  <= prefix_addr;
			len_q  <= prefix_len;
			nh_q   <= route_next_hop;
			ifc_q  <= route_iface;
			met_q  <= route_metric;
			addr_q <= lookup_addr;
		end
		if (key_hit) begin
			pos_q     <= idx_s1;
			old_nh_q  <= rd_data.nh;
			old_if_q  <= rd_data.ifc;
			old_met_q <= rd_data.met;
		end
		if (lpm_hit) begin
			best_nh_q <= rd_data.nh;
			best_if_q <= rd_data.ifc;
		end
	end

	assign cnt_ext      = {{CNT_OUT_W{1'b0}}, cnt_q};
	assign found        = (req_q == REQ_QUERY) && (best_len_q != '0);
	assign out_next_hop = found ? best_nh_q : '0;
	assign out_iface    = found ? best_if_q : '0;
	assign status       = status_q;
	assign entry_count  = cnt_ext[CNT_OUT_W-1:0];

endmodule

// ===== hw/rtl/routing_table_lpm_engine_core.sv =====
// Routing table engine with longest-prefix-match lookup.
//
// Usage: drive a request on the input ports with start high; it is taken
// at a clock edge where start is high and busy is low. Requests are insert,
// delete, query and RIP merge. Each request gives one result, shown for a
// single cycle with done high; the receiver cannot hold it off, so capture
// found, out_next_hop, out_iface, status and entry_count while done is high.
//
// With N routes stored, the scan reads one entry per cycle through the
// single table read port, ending early on a key hit. A removal then
// compacts the tail at one entry per cycle (read i+1, write i). The
// decide, append and result steps complete the request. The scan stops
// where compaction starts; one request is in flight at a time.
//
// Reset clears the route count and the sequencer; the table memory itself
// is not cleared, since entries at or above the count are never read.
// Depends on rtlpm_pkg, rtlpm_ctrl and rtlpm_mem.
module routing_table_lpm_engine_core
	import rtlpm_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [REQ_W-1:0]     req_type,
	input  logic [IP_W-1:0]      prefix_addr,
	input  logic [LEN_W-1:0]     prefix_len,
	input  logic [IP_W-1:0]      route_next_hop,
	input  logic [IF_W-1:0]      route_iface,
	input  logic [MET_W-1:0]     route_metric,
	input  logic [IP_W-1:0]      lookup_addr,
	output logic                 done,
	output logic                 found,
	output logic [IP_W-1:0]      out_next_hop,
	output logic [IF_W-1:0]      out_iface,
	output logic                 status,
	output logic [CNT_OUT_W-1:0] entry_count
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	entry_t        rd_data;

	rtlpm_ctrl #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.prefix_addr    (prefix_addr),
		.prefix_len     (prefix_len),
		.route_next_hop (route_next_hop),
		.route_iface    (route_iface),
		.route_metric   (route_metric),
		.lookup_addr    (lookup_addr),
		.done           (done),
		.found          (found),
		.out_next_hop   (out_next_hop),
		.out_iface      (out_iface),
		.status         (status),
		.entry_count    (entry_count),
		.wr_en          (wr_en),
		.wr_addr        (wr_addr),
		.wr_data        (wr_data),
		.rd_en          (rd_en),
		.rd_addr        (rd_addr),
		.rd_data        (rd_data)
	);

	rtlpm_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule
